/* hw/rtl/pcg_pkg.sv */
// shared types, sizes and arithmetic constants of the programmable chord generator
// used by pcg_ctrl, pcg_datapath and programmable_chord_generator_core; no dependencies

package pcg_pkg;

    // configuration of the enable table
    localparam int NUM_INTERVALS = 25;
    localparam int NUM_PROGRAMS  = 12;

    localparam int IDX_W = (NUM_INTERVALS > 1) ? $clog2(NUM_INTERVALS) : 1;
    localparam int CNT_W = $clog2(NUM_INTERVALS + 1);
    localparam int ROW_W = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1;

    // field widths of the stream items
    localparam int PROGRAM_REQ_W   = 4;
    localparam int BUTTON_W        = 25;
    localparam int PITCH_W         = 15;
    localparam int GATE_W          = 15;
    localparam int NOTE_W          = 9;
    localparam int GATE_OUT_W      = 14;
    localparam int VOICE_INDEX_W   = 5;
    localparam int VOICE_COUNT_W   = 5;
    localparam int ROOT_KEY_W      = 4;
    localparam int PROGRAM_KEY_W   = 4;
    localparam int IN_TDATA_W      = 64;
    localparam int OUT_TDATA_W     = 48;

    // pitch rounding: floor((12 * mv + 500) / 1000) with a positive bias of 200 semitones
    localparam int NUM_W           = 19;
    localparam int BIAS_NUM        = 200500;
    localparam int RECIP_SHIFT     = 28;
    localparam int RECIP_1000      = 268436;   // ceil(2^28 / 1000), exact for numerators < 493000
    localparam int PROD_W          = 38;
    localparam int QUOT_W          = 9;
    localparam int ROOT_OFFSET     = 200;
    localparam int KEY_OFFSET      = 40;       // (root + 240) mod 12 == (quotient + 40) mod 12
    localparam int RECIP_12        = 171;      // x * 171 >> 11 == x / 12 for x < 504
    localparam int RECIP_12_SHIFT  = 11;
    localparam int KEY_PROD_W      = 17;
    localparam int GATE_MAX        = 10000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_ROOT,
        ST_EMIT
    } pcg_state_t;

    typedef struct packed {
        logic capture;
        logic calc;
        logic root;
        logic emit;
    } pcg_cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_last;
    } pcg_status_t;

endpackage

/* hw/rtl/pcg_ctrl.sv */
// sequencing state machine of the chord generator: accept, decode, root, voice emission
// depends on pcg_pkg for the state, command and status types

module pcg_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pcg_pkg::pcg_status_t status,
    output pcg_pkg::pcg_cmd_t    cmd
);

    pcg_pkg::pcg_state_t state_reg;
    pcg_pkg::pcg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pcg_pkg::ST_CALC;
                end
            end
            pcg_pkg::ST_CALC:
            begin
                state_next = pcg_pkg::ST_ROOT;
            end
            pcg_pkg::ST_ROOT:
            begin
                state_next = pcg_pkg::ST_EMIT;
            end
            pcg_pkg::ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                begin
                    state_next = pcg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.calc    = 1'b0;
        cmd.root    = 1'b0;
        cmd.emit    = 1'b0;
        unique case (state_reg)
            pcg_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            pcg_pkg::ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            pcg_pkg::ST_ROOT:
            begin
                cmd.root = 1'b1;
            end
            pcg_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // each accepted transaction runs decode and then root computation, with no stall between them
    a_capture_then_calc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.calc)
        else $error("decode step did not follow an accepted transaction");

    a_calc_then_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc |=> cmd.root)
        else $error("root step did not follow decode");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.calc || cmd.root || cmd.emit) |-> !in_ready)
        else $error("input ready while an item is in progress");

endmodule

/* hw/rtl/pcg_datapath.sv */
// datapath of the chord generator: input capture, enable table with button toggles,
// pitch rounding, voice scan and output register; depends on pcg_pkg

module pcg_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pcg_pkg::pcg_cmd_t                     cmd,
    output pcg_pkg::pcg_status_t                  status,
    input  logic [pcg_pkg::PROGRAM_REQ_W-1:0]     program_req,
    input  logic [pcg_pkg::BUTTON_W-1:0]          button_levels,
    input  logic signed [pcg_pkg::PITCH_W-1:0]    pitch_mv,
    input  logic signed [pcg_pkg::GATE_W-1:0]     gate_mv,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [pcg_pkg::NOTE_W-1:0]     note_semitone,
    output logic [pcg_pkg::GATE_OUT_W-1:0]        gate_out_mv,
    output logic [pcg_pkg::VOICE_INDEX_W-1:0]     voice_index,
    output logic [pcg_pkg::VOICE_COUNT_W-1:0]     voice_count,
    output logic                                  has_voice,
    output logic                                  last,
    output logic [pcg_pkg::ROOT_KEY_W-1:0]        root_key,
    output logic [pcg_pkg::PROGRAM_KEY_W-1:0]     program_key
);

    // enable table and button history
    logic [pcg_pkg::NUM_INTERVALS-1:0]    table_reg [pcg_pkg::NUM_PROGRAMS];
    logic [pcg_pkg::NUM_INTERVALS-1:0]    prev_reg;

    // captured item
    logic [pcg_pkg::ROW_W-1:0]            row_reg;
    logic [pcg_pkg::NUM_INTERVALS-1:0]    levels_reg;
    logic [pcg_pkg::NUM_W-1:0]            num_reg;
    logic [pcg_pkg::GATE_OUT_W-1:0]       gate_reg;

    // decode results
    logic [pcg_pkg::PROD_W-1:0]           prod_reg;
    logic [pcg_pkg::NUM_INTERVALS-1:0]    mask_reg;
    logic [pcg_pkg::CNT_W-1:0]            count_reg;
    logic [pcg_pkg::IDX_W-1:0]            k_reg;
    logic signed [pcg_pkg::NOTE_W-1:0]    root_reg;
    logic [pcg_pkg::ROOT_KEY_W-1:0]       rkey_reg;

    // output register
    logic                                 out_valid_reg;
    logic signed [pcg_pkg::NOTE_W-1:0]    note_reg;
    logic [pcg_pkg::GATE_OUT_W-1:0]       gate_out_reg;
    logic [pcg_pkg::VOICE_INDEX_W-1:0]    index_reg;
    logic [pcg_pkg::VOICE_COUNT_W-1:0]    vcount_reg;
    logic                                 has_voice_reg;
    logic                                 last_reg;
    logic [pcg_pkg::ROOT_KEY_W-1:0]       root_key_reg;
    logic [pcg_pkg::PROGRAM_KEY_W-1:0]    program_key_reg;

    // capture logic
    logic [pcg_pkg::PROGRAM_REQ_W:0]      prog_ext;
    logic [pcg_pkg::PROGRAM_REQ_W:0]      prog_sat;
    logic [pcg_pkg::ROW_W-1:0]            row_sel;
    logic signed [pcg_pkg::NUM_W:0]       pitch_ext;
    logic signed [pcg_pkg::NUM_W:0]       num_full;
    logic [pcg_pkg::GATE_OUT_W-1:0]       gate_sat;

    // decode logic
    logic [pcg_pkg::NUM_INTERVALS-1:0]    new_row;
    logic [pcg_pkg::CNT_W-1:0]            pop;

    // root logic
    logic [pcg_pkg::QUOT_W-1:0]           quot;
    logic signed [pcg_pkg::QUOT_W:0]      root_full;
    logic [pcg_pkg::QUOT_W-1:0]           key_x;
    logic [pcg_pkg::KEY_PROD_W-1:0]       key_prod;
    logic [pcg_pkg::QUOT_W-1:0]           key_div;
    logic [pcg_pkg::QUOT_W-1:0]           key_rem;

    // emit logic
    logic [pcg_pkg::IDX_W-1:0]            first_idx;
    logic signed [pcg_pkg::NOTE_W-1:0]    note_calc;
    logic                                 emit_last;

    always_comb
    begin
        prog_ext = {1'b0, program_req};
        if (prog_ext < (pcg_pkg::PROGRAM_REQ_W + 1)'(1))
        begin
            prog_sat = (pcg_pkg::PROGRAM_REQ_W + 1)'(1);
        end
        else if (prog_ext > (pcg_pkg::PROGRAM_REQ_W + 1)'(pcg_pkg::NUM_PROGRAMS))
        begin
            prog_sat = (pcg_pkg::PROGRAM_REQ_W + 1)'(pcg_pkg::NUM_PROGRAMS);
        end
        else
        begin
            prog_sat = prog_ext;
        end
        // the top program wraps to row 0
        if (prog_sat == (pcg_pkg::PROGRAM_REQ_W + 1)'(pcg_pkg::NUM_PROGRAMS))
        begin
            row_sel = '0;
        end
        else
        begin
            row_sel = pcg_pkg::ROW_W'(prog_sat);
        end
    end

    always_comb
    begin
        pitch_ext = (pcg_pkg::NUM_W + 1)'(pitch_mv);
        num_full  = pitch_ext * (pcg_pkg::NUM_W + 1)'(12)
                  + (pcg_pkg::NUM_W + 1)'(pcg_pkg::BIAS_NUM);
    end

    always_comb
    begin
        if (gate_mv < 0)
        begin
            gate_sat = '0;
        end
        else if (gate_mv > pcg_pkg::GATE_W'(pcg_pkg::GATE_MAX))
        begin
            gate_sat = pcg_pkg::GATE_OUT_W'(pcg_pkg::GATE_MAX);
        end
        else
        begin
            gate_sat = gate_mv[pcg_pkg::GATE_OUT_W-1:0];
        end
    end

    // toggle on rising button edges, then count enabled intervals
    always_comb
    begin
        new_row = table_reg[row_reg] ^ (levels_reg & ~prev_reg);
        pop     = '0;
        for (int j = 0; j < pcg_pkg::NUM_INTERVALS; j++)
        begin
            pop = pop + pcg_pkg::CNT_W'(new_row[j]);
        end
    end

    always_comb
    begin
        quot      = prod_reg[pcg_pkg::RECIP_SHIFT +: pcg_pkg::QUOT_W];
        root_full = $signed({1'b0, quot}) - (pcg_pkg::QUOT_W + 1)'(pcg_pkg::ROOT_OFFSET);
        key_x     = quot + pcg_pkg::QUOT_W'(pcg_pkg::KEY_OFFSET);
        key_prod  = pcg_pkg::KEY_PROD_W'(key_x) * pcg_pkg::KEY_PROD_W'(pcg_pkg::RECIP_12);
        key_div   = pcg_pkg::QUOT_W'(key_prod >> pcg_pkg::RECIP_12_SHIFT);
        key_rem   = key_x - (key_div << 3) - (key_div << 2);
    end

    // lowest remaining enabled interval
    always_comb
    begin
        first_idx = '0;
        for (int j = pcg_pkg::NUM_INTERVALS - 1; j >= 0; j--)
        begin
            if (mask_reg[j])
            begin
                first_idx = pcg_pkg::IDX_W'(j);
            end
        end
        note_calc = root_reg + $signed(pcg_pkg::NOTE_W'(first_idx));
        emit_last = (count_reg == '0)
                 || (pcg_pkg::CNT_W'(k_reg) + pcg_pkg::CNT_W'(1) == count_reg);
    end

    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.emit_last = emit_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < pcg_pkg::NUM_PROGRAMS; r++)
            begin
                table_reg[r] <= '0;
            end
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.calc)
            begin
                table_reg[row_reg] <= new_row;
                prev_reg           <= levels_reg;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg    <= row_sel;
            levels_reg <= pcg_pkg::NUM_INTERVALS'(button_levels);
            num_reg    <= num_full[pcg_pkg::NUM_W-1:0];
            gate_reg   <= gate_sat;
        end
        if (cmd.calc)
        begin
            prod_reg  <= pcg_pkg::PROD_W'(num_reg) * pcg_pkg::PROD_W'(pcg_pkg::RECIP_1000);
            mask_reg  <= new_row;
            count_reg <= pop;
            k_reg     <= '0;
        end
        if (cmd.root)
        begin
            root_reg <= root_full[pcg_pkg::NOTE_W-1:0];
            rkey_reg <= key_rem[pcg_pkg::ROOT_KEY_W-1:0];
        end
        if (cmd.emit)
        begin
            root_key_reg    <= rkey_reg;
            program_key_reg <= pcg_pkg::PROGRAM_KEY_W'(row_reg);
            last_reg        <= emit_last;
            if (count_reg == '0)
            begin
                // empty chord
                note_reg      <= '0;
                gate_out_reg  <= '0;
                index_reg     <= '0;
                vcount_reg    <= '0;
                has_voice_reg <= 1'b0;
            end
            else
            begin
                note_reg            <= note_calc;
                gate_out_reg        <= gate_reg;
                index_reg           <= pcg_pkg::VOICE_INDEX_W'(k_reg);
                vcount_reg          <= pcg_pkg::VOICE_COUNT_W'(count_reg);
                has_voice_reg       <= 1'b1;
                mask_reg[first_idx] <= 1'b0;
                k_reg               <= k_reg + pcg_pkg::IDX_W'(1);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign note_semitone = note_reg;
    assign gate_out_mv   = gate_out_reg;
    assign voice_index   = index_reg;
    assign voice_count   = vcount_reg;
    assign has_voice     = has_voice_reg;
    assign last          = last_reg;
    assign root_key      = root_key_reg;
    assign program_key   = program_key_reg;

    a_emit_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("voice loaded while output register still held");

    a_index_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && has_voice_reg) |-> (index_reg < vcount_reg))
        else $error("voice index not below voice count");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !has_voice_reg) |-> (last_reg && vcount_reg == '0))
        else $error("empty chord result malformed");

    a_voice_has_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && count_reg != '0) |-> (mask_reg != '0))
        else $error("voice emitted with no enabled interval left");

endmodule

/* hw/rtl/programmable_chord_generator_core.sv */
// an accepted transaction passes the capture, decode and root steps, and its first voice is
// then registered once the output register is free; the voice scan loads one voice per cycle
// into the output register while it is free, one per enabled voice or one for an empty chord
// a voice waiting in the output register does not block acceptance of the next transaction
// reset (rst_n low, asynchronous): enable table and button history cleared, output empty, idle
// depends on pcg_pkg, pcg_ctrl and pcg_datapath

module programmable_chord_generator_core
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // program_req, button_levels, pitch_mv, gate_mv, zero pad
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // note_semitone, gate_out_mv, voice_index, voice_count,
                                        // root_key, program_key, zero pad
    output logic        m_axis_tuser,   // has_voice
    output logic        m_axis_tlast    // last voice of the transaction
);

    pcg_pkg::pcg_cmd_t    cmd;
    pcg_pkg::pcg_status_t status;

    // unpacked input fields, lowest bits first
    logic [pcg_pkg::PROGRAM_REQ_W-1:0]  program_req;
    logic [pcg_pkg::BUTTON_W-1:0]       button_levels;
    logic signed [pcg_pkg::PITCH_W-1:0] pitch_mv;
    logic signed [pcg_pkg::GATE_W-1:0]  gate_mv;

    // result fields
    logic signed [pcg_pkg::NOTE_W-1:0]  note_semitone;
    logic [pcg_pkg::GATE_OUT_W-1:0]     gate_out_mv;
    logic [pcg_pkg::VOICE_INDEX_W-1:0]  voice_index;
    logic [pcg_pkg::VOICE_COUNT_W-1:0]  voice_count;
    logic [pcg_pkg::ROOT_KEY_W-1:0]     root_key;
    logic [pcg_pkg::PROGRAM_KEY_W-1:0]  program_key;

    assign program_req   = s_axis_tdata[3:0];
    assign button_levels = s_axis_tdata[28:4];
    assign pitch_mv      = s_axis_tdata[43:29];
    assign gate_mv       = s_axis_tdata[58:44];

    // sequencer: idle/accept, decode and toggle, root rounding, voice emission
    pcg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // enable table, arithmetic and the output register
    pcg_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .program_req   (program_req),
        .button_levels (button_levels),
        .pitch_mv      (pitch_mv),
        .gate_mv       (gate_mv),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .note_semitone (note_semitone),
        .gate_out_mv   (gate_out_mv),
        .voice_index   (voice_index),
        .voice_count   (voice_count),
        .has_voice     (m_axis_tuser),
        .last          (m_axis_tlast),
        .root_key      (root_key),
        .program_key   (program_key)
    );

    // pack result fields, lowest field first, zero pad to whole bytes
    assign m_axis_tdata = {7'd0, program_key, root_key, voice_count, voice_index,
                           gate_out_mv, note_semitone};

endmodule
